// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the monitor RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while reset is released.
`define STHM_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define STHM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/sthm_pkg.sv =====
// Package with constants, types and health-code functions of the timing monitor.
`timescale 1ns / 1ps

package sthm_pkg;

  localparam int RATE_FRAC_BITS_DEF = 8;
  localparam int TIME_BITS_DEF      = 63;
  localparam int FIFO_DEPTH         = 4;

  localparam int          NS_PER_S_W = 30;
  localparam logic [29:0] NS_PER_S   = 30'd1000000000;

  // floor(d / 10) == (d * DIV10_MUL) >> DIV10_SHIFT for any d below 2^32.
  localparam logic [31:0] DIV10_MUL   = 32'hCCCCCCCD;
  localparam int          DIV10_SHIFT = 35;

  localparam int NOMINAL_W  = 24;
  localparam int TOL_W      = 16;
  localparam int GAP_W      = 40;
  localparam int SRC_W      = 3;
  localparam int CFG_DATA_W = 40;
  localparam int CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] REG_NOMINAL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TOL     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAP     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE  = 2'd3;

  localparam logic [TOL_W-1:0] TOL_RESET = 16'd6554;
  localparam logic [GAP_W-1:0] GAP_RESET = 40'd1000000000;
  localparam logic [SRC_W-1:0] SRC_RESET = 3'd3;

  localparam logic [1:0] FUNC_SAMPLE = 2'd0;
  localparam logic [1:0] FUNC_RAISE  = 2'd1;
  localparam logic [1:0] FUNC_CLEAR  = 2'd2;

  localparam logic [2:0] CODE_NONE        = 3'd0;
  localparam logic [2:0] CODE_CLOCK_STEP  = 3'd1;
  localparam logic [2:0] CODE_DROPOUT     = 3'd2;
  localparam logic [2:0] CODE_RATE_LOW    = 3'd3;
  localparam logic [2:0] CODE_RATE_HIGH   = 3'd4;
  localparam logic [2:0] CODE_SYNC_LOST   = 3'd5;

  localparam logic [SRC_W-1:0] SRC_ARRIVAL   = 3'd0;
  localparam logic [SRC_W-1:0] SRC_SW_OFFSET = 3'd2;

  localparam logic [1:0] LVL_NOMINAL  = 2'd0;
  localparam logic [1:0] LVL_DEGRADED = 2'd1;
  localparam logic [1:0] LVL_FAILED   = 2'd2;

  localparam logic [6:0] FAILED_MASK   = 7'h60;
  localparam logic [6:0] DEGRADED_MASK = 7'h1F;

  typedef struct packed {
    logic [6:0] flags;
    logic [1:0] level;
    logic       chg;
  } health_t;

  function automatic logic [1:0] level_of(input logic [6:0] f);
    logic [1:0] l;
    if ((f & FAILED_MASK) != 7'd0) l = LVL_FAILED;
    else if ((f & DEGRADED_MASK) != 7'd0) l = LVL_DEGRADED;
    else l = LVL_NOMINAL;
    return l;
  endfunction

  function automatic logic [2:0] dominant_of(input logic [6:0] f);
    logic [2:0] d;
    d = CODE_NONE;
    for (int i = 6; i >= 0; i--) begin
      if (f[i]) d = 3'(i + 1);
    end
    return d;
  endfunction

  function automatic health_t set_code(input health_t h, input logic [2:0] code,
                                       input logic on);
    health_t    r;
    logic [6:0] msk;
    logic [6:0] nxt;
    r = h;
    if (code != CODE_NONE) begin
      msk = 7'd1 << (code - 3'd1);
      nxt = on ? (h.flags | msk) : (h.flags & ~msk);
      if (nxt != h.flags) begin
        r.flags = nxt;
        r.level = level_of(nxt);
        if (r.level != h.level) r.chg = 1'b1;
      end
    end
    return r;
  endfunction

endpackage

// ===== rtl/sthm_front.sv =====
// Front end: clamps sample stamps, measures the gap and packs each word for the queue.
`timescale 1ns / 1ps

module sthm_front import sthm_pkg::*; #(
  parameter int TIME_BITS = TIME_BITS_DEF,
  parameter int WORD_W    = 2 * TIME_BITS + 10
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_push,
  output logic                 in_full,
  input  logic [1:0]           in_func,
  input  logic [TIME_BITS-1:0] in_timestamp,
  input  logic [SRC_W-1:0]     in_stamp_source,
  input  logic [2:0]           in_event_code,
  input  logic                 q_full,
  output logic                 q_wr,
  output logic [WORD_W-1:0]    q_word
);

  logic [TIME_BITS-1:0] last_r;
  logic                 have_r;
  logic                 is_sample;
  logic                 clamp;
  logic [TIME_BITS-1:0] stamp;
  logic [TIME_BITS-1:0] gap;

  assign is_sample = (in_func == FUNC_SAMPLE);
  assign clamp     = is_sample && (in_timestamp < last_r);
  assign stamp     = clamp ? last_r : in_timestamp;
  assign gap       = stamp - last_r;
  assign in_full   = q_full;
  assign q_wr      = in_push && !q_full;
  assign q_word    = {in_func, in_stamp_source, in_event_code, have_r, clamp, stamp, gap};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r <= '0;
      have_r <= 1'b0;
    end else if (q_wr && is_sample) begin
      last_r <= stamp;
      have_r <= 1'b1;
    end
  end

endmodule

// ===== rtl/sthm_fifo.sv =====
// Short queue that decouples the front end from the back end.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sthm_fifo import sthm_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = FIFO_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wp_r;
  logic [PW-1:0]    rp_r;
  logic [CW-1:0]    cnt_r;
  logic             do_wr;
  logic             do_rd;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (do_wr) mem_r[wp_r] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_wr) wp_r <= (wp_r == PW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
      if (do_rd) rp_r <= (rp_r == PW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
      if (do_wr && !do_rd) cnt_r <= cnt_r + 1'b1;
      else if (do_rd && !do_wr) cnt_r <= cnt_r - 1'b1;
    end
  end

  `STHM_ASSERT(a_cnt_bound, clk, rst_n, cnt_r <= CW'(DEPTH), "queue count exceeds depth")
  `STHM_ASSERT(a_cnt_inc, clk, rst_n, (do_wr && !do_rd) |=> (cnt_r == $past(cnt_r) + 1'b1), "queue count did not grow")
  `STHM_ASSERT_ALWAYS(a_rst_empty, clk, !rst_n |=> (cnt_r == '0), "queue not empty after reset")

endmodule

// ===== rtl/sthm_back.sv =====
// Back end: rate divider, smoothing, health-code update and result register.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sthm_back import sthm_pkg::*; #(
  parameter int RATE_FRAC_BITS = RATE_FRAC_BITS_DEF,
  parameter int TIME_BITS      = TIME_BITS_DEF,
  parameter int WORD_W         = 2 * TIME_BITS + 10,
  parameter int RW             = 16 + RATE_FRAC_BITS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [NOMINAL_W-1:0] nominal,
  input  logic [TOL_W-1:0]     tol,
  input  logic [GAP_W-1:0]     gap_lim,
  input  logic [SRC_W-1:0]     src_cfg,
  input  logic                 q_empty,
  input  logic [WORD_W-1:0]    q_word,
  output logic                 q_rd,
  input  logic                 out_pop,
  output logic                 out_empty,
  output logic [TIME_BITS-1:0] out_stamp_out,
  output logic [1:0]           out_level,
  output logic [2:0]           out_dominant_code,
  output logic [6:0]           out_active_codes,
  output logic [RW-1:0]        out_rate_estimate,
  output logic [TIME_BITS-1:0] out_level_since
);

  localparam int DVD_W = NS_PER_S_W + RATE_FRAC_BITS;
  localparam int DCW   = $clog2(DVD_W);
  localparam int BND_W = NOMINAL_W + 17;
  localparam int CMP_W = (RW + 16 > BND_W) ? RW + 16 : BND_W;
  localparam int GCW   = (TIME_BITS > GAP_W) ? TIME_BITS : GAP_W;
  localparam int PRD_W = RW + 32;
  localparam logic [DVD_W-1:0] DIVIDEND = {NS_PER_S, RATE_FRAC_BITS'(0)};
  localparam logic [RW-1:0]    RATE_MAX = '1;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DIV  = 3'd1;
  localparam logic [2:0] ST_DIFF = 3'd2;
  localparam logic [2:0] ST_MUL  = 3'd3;
  localparam logic [2:0] ST_ADJ  = 3'd4;
  localparam logic [2:0] ST_FIN  = 3'd5;

  logic [2:0]           state_r;
  logic [1:0]           func_r;
  logic [SRC_W-1:0]     src_r;
  logic [2:0]           code_r;
  logic                 have_r;
  logic                 clamp_r;
  logic [TIME_BITS-1:0] stamp_r;
  logic [TIME_BITS-1:0] gap_r;
  logic [TIME_BITS-1:0] rem_r;
  logic [DVD_W-1:0]     dvd_r;
  logic [DVD_W-1:0]     quo_r;
  logic [DCW-1:0]       cnt_r;
  logic                 up_r;
  logic [RW-1:0]        diff_r;
  logic [PRD_W-1:0]     prod_r;
  logic [RW-1:0]        rate_new_r;
  logic [BND_W-1:0]     lo_r;
  logic [BND_W-1:0]     hi_r;
  logic [RW-1:0]        rate_r;
  logic [6:0]           flags_r;
  logic [1:0]           level_r;
  logic [TIME_BITS-1:0] since_r;
  logic [TIME_BITS-1:0] out_stamp_r;
  logic                 out_valid_r;

  logic [TIME_BITS:0]   rem_sh;
  logic                 rem_ge;
  logic [RW-1:0]        inst;
  logic [RW-4:0]        q10;
  logic [CMP_W-1:0]     scaled;
  logic                 fin_go;
  logic                 fin_wait;
  logic                 fails_now;
  health_t              h;

  assign q_rd      = (state_r == ST_IDLE) && !q_empty;
  assign fin_go    = (state_r == ST_FIN) && (!out_valid_r || out_pop);
  assign fin_wait  = (state_r == ST_FIN) && out_valid_r && !out_pop;
  assign fails_now = (flags_r & FAILED_MASK) != 7'd0;
  assign rem_sh    = {rem_r, dvd_r[DVD_W-1]};
  assign rem_ge    = rem_sh >= {1'b0, gap_r};
  assign inst      = (quo_r[DVD_W-1:RW] != '0) ? RATE_MAX : quo_r[RW-1:0];
  assign q10       = prod_r[DIV10_SHIFT +: RW - 3];
  assign scaled    = CMP_W'({rate_new_r, 16'd0});

  always_comb begin
    h = '{flags: flags_r, level: level_r, chg: 1'b0};
    if (func_r == FUNC_SAMPLE) begin
      if (clamp_r) h = set_code(h, CODE_CLOCK_STEP, 1'b1);
      if (have_r) begin
        h = set_code(h, CODE_DROPOUT, GCW'(gap_r) > GCW'(gap_lim));
        if (nominal != '0 && rate_new_r != '0) begin
          if (scaled < CMP_W'(lo_r)) begin
            h = set_code(h, CODE_RATE_HIGH, 1'b0);
            h = set_code(h, CODE_RATE_LOW, 1'b1);
          end else if (scaled > CMP_W'(hi_r)) begin
            h = set_code(h, CODE_RATE_LOW, 1'b0);
            h = set_code(h, CODE_RATE_HIGH, 1'b1);
          end else begin
            h = set_code(h, CODE_RATE_LOW, 1'b0);
            h = set_code(h, CODE_RATE_HIGH, 1'b0);
          end
        end
      end
      if (src_r == SRC_SW_OFFSET && src_cfg != SRC_SW_OFFSET
          && src_cfg != SRC_ARRIVAL) begin
        h = set_code(h, CODE_SYNC_LOST, 1'b1);
      end else if (src_r == src_cfg) begin
        h = set_code(h, CODE_SYNC_LOST, 1'b0);
      end
    end else if (func_r == FUNC_RAISE) begin
      h = set_code(h, code_r, 1'b1);
    end else if (func_r == FUNC_CLEAR) begin
      h = set_code(h, code_r, 1'b0);
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (q_rd) begin
          {func_r, src_r, code_r, have_r, clamp_r, stamp_r, gap_r} <= q_word;
          rem_r      <= '0;
          dvd_r      <= DIVIDEND;
          quo_r      <= '0;
          cnt_r      <= '0;
          rate_new_r <= rate_r;
          lo_r <= BND_W'(nominal) * BND_W'(17'd65536 - {1'b0, tol});
          hi_r <= BND_W'(nominal) * BND_W'(17'd65536 + {1'b0, tol});
        end
      end
      ST_DIV: begin
        rem_r <= rem_ge ? TIME_BITS'(rem_sh - {1'b0, gap_r}) : rem_sh[TIME_BITS-1:0];
        quo_r <= {quo_r[DVD_W-2:0], rem_ge};
        dvd_r <= {dvd_r[DVD_W-2:0], 1'b0};
        cnt_r <= cnt_r + 1'b1;
      end
      ST_DIFF: begin
        if (rate_r == '0) rate_new_r <= inst;
        up_r   <= inst >= rate_r;
        diff_r <= (inst >= rate_r) ? inst - rate_r : rate_r - inst;
      end
      ST_MUL: begin
        prod_r <= PRD_W'(diff_r) * PRD_W'(DIV10_MUL);
      end
      ST_ADJ: begin
        rate_new_r <= up_r ? rate_r + RW'(q10) : rate_r - RW'(q10);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rate_r      <= '0;
      flags_r     <= '0;
      level_r     <= LVL_NOMINAL;
      since_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (fin_go) out_valid_r <= 1'b1;
      else if (out_pop && out_valid_r) out_valid_r <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (q_rd) begin
            if (q_word[WORD_W-1 -: 2] == FUNC_SAMPLE && q_word[2*TIME_BITS+1]
                && q_word[TIME_BITS-1:0] != '0) begin
              state_r <= ST_DIV;
            end else begin
              state_r <= ST_FIN;
            end
          end
        end
        ST_DIV: begin
          if (cnt_r == DCW'(DVD_W - 1)) state_r <= ST_DIFF;
        end
        ST_DIFF: begin
          state_r <= (rate_r == '0) ? ST_FIN : ST_MUL;
        end
        ST_MUL: state_r <= ST_ADJ;
        ST_ADJ: state_r <= ST_FIN;
        ST_FIN: begin
          if (fin_go) begin
            flags_r     <= h.flags;
            level_r     <= h.level;
            if (h.chg) since_r <= stamp_r;
            rate_r      <= rate_new_r;
            out_stamp_r <= stamp_r;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_empty         = !out_valid_r;
  assign out_stamp_out     = out_stamp_r;
  assign out_level         = level_r;
  assign out_dominant_code = dominant_of(flags_r);
  assign out_active_codes  = flags_r;
  assign out_rate_estimate = rate_r;
  assign out_level_since   = since_r;

  `STHM_ASSERT(a_level_match, clk, rst_n, (level_r == LVL_FAILED) == fails_now, "bad level")
  `STHM_ASSERT(a_div_gap, clk, rst_n, (state_r == ST_DIV) |-> (gap_r != '0), "zero gap")
  `STHM_ASSERT(a_fin_hold, clk, rst_n, fin_wait |=> (state_r == ST_FIN), "result overwritten")

endmodule

// ===== rtl/sensor_timing_health_monitor.sv =====
// Top level of the sensor timing health monitor with its configuration registers.
//
//   Channel  Handshake            Moves
//   input    in_push / in_full    one sample or event word
//   output   out_pop / out_empty  one status word per input word
//   config   cfg_we               one register write, index and data
//
// A sample with a previous sample and a nonzero gap reaches the result register through
// the queue, 30 + RATE_FRAC_BITS divider steps, the difference, the multiply by one
// tenth, the adjust and the final update. While the estimate is still zero the multiply
// and the adjust are skipped; other words go from the queue straight to the final
// update. A four-word queue lets the front end keep accepting while the back end works.
// Reset is synchronous and clears the control state and loads the register defaults. A
// full output register stalls the back end, and the front end too once the queue fills.
`timescale 1ns / 1ps

module sensor_timing_health_monitor import sthm_pkg::*; #(
  parameter int RATE_FRAC_BITS = RATE_FRAC_BITS_DEF,
  parameter int TIME_BITS      = TIME_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [CFG_DATA_W-1:0]        cfg_wdata,
  input  logic                         in_push,
  output logic                         in_full,
  input  logic [1:0]                   in_func,
  input  logic [TIME_BITS-1:0]         in_timestamp,
  input  logic [SRC_W-1:0]             in_stamp_source,
  input  logic [2:0]                   in_event_code,
  input  logic                         out_pop,
  output logic                         out_empty,
  output logic [TIME_BITS-1:0]         out_stamp_out,
  output logic [1:0]                   out_level,
  output logic [2:0]                   out_dominant_code,
  output logic [6:0]                   out_active_codes,
  output logic [16+RATE_FRAC_BITS-1:0] out_rate_estimate,
  output logic [TIME_BITS-1:0]         out_level_since
);

  localparam int WORD_W = 2 * TIME_BITS + 10;

  logic [NOMINAL_W-1:0] nominal_r;
  logic [TOL_W-1:0]     tol_r;
  logic [GAP_W-1:0]     gap_r;
  logic [SRC_W-1:0]     src_r;
  logic                 q_wr;
  logic                 q_rd;
  logic                 q_full;
  logic                 q_empty;
  logic [WORD_W-1:0]    q_wdata;
  logic [WORD_W-1:0]    q_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nominal_r <= '0;
      tol_r     <= TOL_RESET;
      gap_r     <= GAP_RESET;
      src_r     <= SRC_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_NOMINAL: nominal_r <= cfg_wdata[NOMINAL_W-1:0];
        REG_TOL:     tol_r     <= cfg_wdata[TOL_W-1:0];
        REG_GAP:     gap_r     <= cfg_wdata[GAP_W-1:0];
        REG_SOURCE:  src_r     <= cfg_wdata[SRC_W-1:0];
        default: begin
        end
      endcase
    end
  end

  sthm_front #(.TIME_BITS(TIME_BITS), .WORD_W(WORD_W)) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_push         (in_push),
    .in_full         (in_full),
    .in_func         (in_func),
    .in_timestamp    (in_timestamp),
    .in_stamp_source (in_stamp_source),
    .in_event_code   (in_event_code),
    .q_full          (q_full),
    .q_wr            (q_wr),
    .q_word          (q_wdata)
  );

  sthm_fifo #(.WIDTH(WORD_W), .DEPTH(FIFO_DEPTH)) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (q_wr),
    .wr_data (q_wdata),
    .full    (q_full),
    .rd_en   (q_rd),
    .rd_data (q_rdata),
    .empty   (q_empty)
  );

  sthm_back #(
    .RATE_FRAC_BITS (RATE_FRAC_BITS),
    .TIME_BITS      (TIME_BITS),
    .WORD_W         (WORD_W),
    .RW             (16 + RATE_FRAC_BITS)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .nominal           (nominal_r),
    .tol               (tol_r),
    .gap_lim           (gap_r),
    .src_cfg           (src_r),
    .q_empty           (q_empty),
    .q_word            (q_rdata),
    .q_rd              (q_rd),
    .out_pop           (out_pop),
    .out_empty         (out_empty),
    .out_stamp_out     (out_stamp_out),
    .out_level         (out_level),
    .out_dominant_code (out_dominant_code),
    .out_active_codes  (out_active_codes),
    .out_rate_estimate (out_rate_estimate),
    .out_level_since   (out_level_since)
  );

endmodule

// ===== tb/tb_sensor_timing_health_monitor.sv =====
// Self-checking testbench for the sensor timing health monitor with a scoreboard class.
`timescale 1ns / 1ps

module tb_sensor_timing_health_monitor;
  import sthm_pkg::*;

  localparam logic [1:0] FUNC_IDLE            = 2'd3;
  localparam logic [2:0] CODE_NO_POINT_TIME   = 3'd6;
  localparam logic [2:0] CODE_EMPTY_SCAN      = 3'd7;
  localparam int         STALL_LIMIT          = 5000;
  localparam logic [62:0] STAMP_MAX           = {63{1'b1}};
  localparam longint unsigned RATE_LIMIT      = 64'hFFFFFF;

  typedef struct packed {
    logic [62:0] stamp;
    logic [1:0]  level;
    logic [2:0]  dominant;
    logic [6:0]  codes;
    logic [23:0] rate;
    logic [62:0] since;
  } status_t;

  class health_scoreboard;
    logic [62:0]     newest_stamp;
    logic [62:0]     prior_sample;
    bit              seen_sample;
    longint unsigned smoothed_rate;
    logic [6:0]      flags;
    logic [1:0]      lvl;
    logic [62:0]     lvl_time;
    longint unsigned nominal;
    longint unsigned tolerance;
    longint unsigned gap_limit;
    logic [2:0]      home_source;
    status_t         pending[$];
    int              errors;

    function void clear();
      newest_stamp = '0; prior_sample = '0; seen_sample = 0; smoothed_rate = 0;
      flags = '0; lvl = LVL_NOMINAL; lvl_time = '0;
      nominal = 0; tolerance = TOL_RESET; gap_limit = GAP_RESET; home_source = SRC_RESET;
      pending.delete(); errors = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_NOMINAL: nominal = val[23:0];
        REG_TOL:     tolerance = val[15:0];
        REG_GAP:     gap_limit = val[39:0];
        default:     home_source = val[2:0];
      endcase
    endfunction

    function void update_code(logic [2:0] code, bit on, logic [62:0] t);
      logic [6:0] nxt;
      logic [1:0] nl;
      if (code == CODE_NONE) return;
      nxt = flags;
      nxt[code - 1] = on;
      if (nxt == flags) return;
      flags = nxt;
      if (flags[6:5] != 0) nl = LVL_FAILED;
      else if (flags[4:0] != 0) nl = LVL_DEGRADED;
      else nl = LVL_NOMINAL;
      if (nl != lvl) lvl_time = t;
      lvl = nl;
    endfunction

    function void track_sample(logic [62:0] t, logic [2:0] src);
      longint unsigned gap, inst, scaled, lo, hi;
      if (seen_sample) begin
        gap = (t >= prior_sample) ? 64'(t - prior_sample) : 0;
        if (gap > 0) begin
          inst = (64'd1000000000 << 8) / gap;
          if (inst > RATE_LIMIT) inst = RATE_LIMIT;
          if (smoothed_rate == 0) smoothed_rate = inst;
          else if (inst >= smoothed_rate) smoothed_rate += (inst - smoothed_rate) / 10;
          else smoothed_rate -= (smoothed_rate - inst) / 10;
        end
        update_code(CODE_DROPOUT, gap > gap_limit, t);
        if (nominal != 0 && smoothed_rate != 0) begin
          scaled = smoothed_rate << 16;
          lo = nominal * (65536 - tolerance);
          hi = nominal * (65536 + tolerance);
          if (scaled < lo) begin
            update_code(CODE_RATE_HIGH, 0, t);
            update_code(CODE_RATE_LOW, 1, t);
          end else if (scaled > hi) begin
            update_code(CODE_RATE_LOW, 0, t);
            update_code(CODE_RATE_HIGH, 1, t);
          end else begin
            update_code(CODE_RATE_LOW, 0, t);
            update_code(CODE_RATE_HIGH, 0, t);
          end
        end
      end
      if (src == SRC_SW_OFFSET && home_source != SRC_SW_OFFSET && home_source != SRC_ARRIVAL)
        update_code(CODE_SYNC_LOST, 1, t);
      else if (src == home_source)
        update_code(CODE_SYNC_LOST, 0, t);
      prior_sample = t;
      seen_sample = 1;
    endfunction

    function void note_word(logic [1:0] func, logic [62:0] ts, logic [2:0] src,
                            logic [2:0] code);
      status_t s;
      logic [62:0] st;
      st = ts;
      if (func == FUNC_SAMPLE) begin
        if (ts < newest_stamp) begin
          st = newest_stamp;
          update_code(CODE_CLOCK_STEP, 1, newest_stamp);
        end else begin
          newest_stamp = ts;
        end
        track_sample(st, src);
      end else if (func == FUNC_RAISE) begin
        update_code(code, 1, ts);
      end else if (func == FUNC_CLEAR) begin
        update_code(code, 0, ts);
      end
      s.stamp = st;
      s.level = lvl;
      s.dominant = CODE_NONE;
      for (int i = 6; i >= 0; i--) if (flags[i]) s.dominant = 3'(i + 1);
      s.codes = flags;
      s.rate = smoothed_rate[23:0];
      s.since = lvl_time;
      pending.push_back(s);
    endfunction

    function void check_word(status_t got);
      status_t want;
      if (pending.size() == 0) begin
        $error("status word with none expected");
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.stamp != want.stamp) begin
        $error("stamp_out exp %0d got %0d", want.stamp, got.stamp); errors++;
      end
      if (got.level != want.level) begin
        $error("level exp %0d got %0d", want.level, got.level); errors++;
      end
      if (got.dominant != want.dominant) begin
        $error("dominant_code exp %0d got %0d", want.dominant, got.dominant); errors++;
      end
      if (got.codes != want.codes) begin
        $error("active_codes exp %h got %h", want.codes, got.codes); errors++;
      end
      if (got.rate != want.rate) begin
        $error("rate_estimate exp %0d got %0d", want.rate, got.rate); errors++;
      end
      if (got.since != want.since) begin
        $error("level_since exp %0d got %0d", want.since, got.since); errors++;
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  in_push;
  logic                  in_full;
  logic [1:0]            in_func;
  logic [62:0]           in_timestamp;
  logic [2:0]            in_stamp_source;
  logic [2:0]            in_event_code;
  logic                  out_pop;
  logic                  out_empty;
  logic [62:0]           out_stamp_out;
  logic [1:0]            out_level;
  logic [2:0]            out_dominant_code;
  logic [6:0]            out_active_codes;
  logic [23:0]           out_rate_estimate;
  logic [62:0]           out_level_since;

  health_scoreboard sb;
  bit          no_idle;
  bit          hold_req;
  int          hold_left;
  int          stall_left;
  int          quiet_cycles;
  logic [62:0] clock_ns;
  logic [2:0]  phase_source;

  sensor_timing_health_monitor u_dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_push(in_push), .in_full(in_full), .in_func(in_func), .in_timestamp(in_timestamp),
    .in_stamp_source(in_stamp_source), .in_event_code(in_event_code),
    .out_pop(out_pop), .out_empty(out_empty), .out_stamp_out(out_stamp_out),
    .out_level(out_level), .out_dominant_code(out_dominant_code),
    .out_active_codes(out_active_codes), .out_rate_estimate(out_rate_estimate),
    .out_level_since(out_level_since)
  );

  always begin
    clk = 1'b1; #2;
    clk = 1'b0; #2;
  end

  always @(negedge clk) begin
    if (hold_req) begin
      hold_req <= 1'b0;
      hold_left <= 400;
      out_pop <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_pop <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_pop <= 1'b0;
    end else if (!no_idle && $urandom_range(0, 4) == 0) begin
      stall_left <= $urandom_range(0, 10);
      out_pop <= 1'b0;
    end else begin
      out_pop <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty)
      sb.check_word({out_stamp_out, out_level, out_dominant_code, out_active_codes,
                     out_rate_estimate, out_level_since});
  end

  always @(posedge clk) begin
    if (!rst_n || (in_push && !in_full) || (out_pop && !out_empty)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic send_word(logic [1:0] func, logic [62:0] ts, logic [2:0] src,
                           logic [2:0] code);
    if (!no_idle && $urandom_range(0, 3) == 0) begin
      in_push = 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
    in_push = 1'b1;
    in_func = func;
    in_timestamp = ts;
    in_stamp_source = src;
    in_event_code = code;
    @(posedge clk);
    while (in_full) @(posedge clk);
    sb.note_word(func, ts, src, code);
    @(negedge clk);
    in_push = 1'b0;
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (60) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    sb.write_reg(idx, val);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic configure(logic [23:0] nom, logic [15:0] tol, logic [39:0] gap,
                           logic [2:0] src);
    drain();
    write_reg(REG_NOMINAL, CFG_DATA_W'(nom));
    write_reg(REG_TOL, CFG_DATA_W'(tol));
    write_reg(REG_GAP, gap);
    write_reg(REG_SOURCE, CFG_DATA_W'(src));
    phase_source = src;
  endtask

  function automatic logic [62:0] any_stamp();
    return 63'({$urandom, $urandom} >> 1);
  endfunction

  task automatic run_phase(int count, longint unsigned period);
    longint unsigned step;
    int          r;
    logic [2:0]  src;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(0, 99);
      if (r < 85) src = phase_source;
      else if (r < 95) src = SRC_SW_OFFSET;
      else src = 3'($urandom_range(0, 7));
      r = $urandom_range(0, 99);
      if (r < 84) begin
        if (r < 60) step = period - period / 8 + $urandom_range(0, 1000) * (period / 4) / 1000;
        else if (r < 68) step = period + period * $urandom_range(3, 10) / 10;
        else if (r < 76) step = period * $urandom_range(5, 8) / 10;
        else if (r < 80) step = period * $urandom_range(3, 6);
        else step = 0;
        clock_ns = clock_ns + step;
        send_word(FUNC_SAMPLE, clock_ns, src, 3'($urandom));
      end else if (r < 87) begin
        send_word(FUNC_SAMPLE, clock_ns - $urandom_range(1, 1000000), src, 3'($urandom));
      end else if (r < 98) begin
        send_word($urandom_range(0, 1) ? FUNC_RAISE : FUNC_CLEAR, any_stamp(),
                  3'($urandom), 3'($urandom));
      end else begin
        send_word(FUNC_IDLE, any_stamp(), 3'($urandom), 3'($urandom));
      end
    end
  endtask

  initial begin
    sb = new();
    sb.clear();
    rst_n = 1'b0;
    cfg_we = 1'b0; cfg_index = '0; cfg_wdata = '0;
    in_push = 1'b0; in_func = FUNC_SAMPLE; in_timestamp = '0;
    in_stamp_source = '0; in_event_code = '0;
    out_pop = 1'b0;
    no_idle = 0; hold_req = 0; hold_left = 0; stall_left = 0; quiet_cycles = 0;
    phase_source = SRC_RESET;
    repeat (3) @(negedge clk);
    rst_n = 1'b1;

    send_word(FUNC_SAMPLE, 63'd1000, SRC_RESET, CODE_NONE);
    send_word(FUNC_SAMPLE, 63'd1001000, SRC_RESET, CODE_NONE);
    send_word(FUNC_SAMPLE, 63'd500, SRC_RESET, CODE_NONE);
    send_word(FUNC_SAMPLE, 63'd1001000, SRC_RESET, CODE_NONE);
    send_word(FUNC_SAMPLE, 63'd1001001, SRC_SW_OFFSET, CODE_NONE);
    send_word(FUNC_SAMPLE, 63'd3001001, SRC_RESET, CODE_NONE);
    send_word(FUNC_SAMPLE, 63'd3001001000, 3'd7, CODE_NONE);
    send_word(FUNC_RAISE, 63'd5000, '0, CODE_NO_POINT_TIME);
    send_word(FUNC_RAISE, STAMP_MAX, '0, CODE_EMPTY_SCAN);
    send_word(FUNC_CLEAR, 63'd7000, '0, CODE_NO_POINT_TIME);
    send_word(FUNC_CLEAR, 63'd8000, '0, CODE_EMPTY_SCAN);
    send_word(FUNC_RAISE, 63'd9000, '0, CODE_NONE);
    send_word(FUNC_CLEAR, 63'd9000, '0, CODE_NONE);
    send_word(FUNC_IDLE, STAMP_MAX, 3'd7, 3'd7);
    for (int c = 1; c <= 5; c++) send_word(FUNC_RAISE, 63'(10000 + c), '0, 3'(c));
    for (int c = 1; c <= 5; c++) send_word(FUNC_CLEAR, 63'(20000 + c), '0, 3'(c));
    clock_ns = 63'd3001001000;

    run_phase(250, 64'd1000000);
    configure(24'd256000, 16'd6554, 40'd2500000, 3'd3);
    hold_req = 1'b1;
    run_phase(280, 64'd1000000);
    configure(24'hFFFFFF, 16'd0, 40'd0, SRC_SW_OFFSET);
    run_phase(140, 64'd16);
    drain();
    run_phase(140, 64'd16);
    configure(24'd25600, 16'hFFFF, 40'hFFFFFFFFFF, SRC_ARRIVAL);
    run_phase(280, 64'd10000000);
    configure(24'd1, 16'd100, 40'd1000000000, 3'd7);
    run_phase(280, 64'd256000000000);
    configure(24'd12800, 16'd3277, 40'd50000000, 3'd1);
    run_phase(280, 64'd20000000);
    clock_ns = STAMP_MAX - 63'd2000000000000;
    run_phase(200, 64'd3000000);
    no_idle = 1;
    run_phase(80, 64'd3000000);
    send_word(FUNC_SAMPLE, STAMP_MAX, phase_source, CODE_NONE);

    while (sb.pending.size() != 0) @(negedge clk);
    repeat (100) @(negedge clk);
    if (sb.errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
